### rtl/core/rbd_pkg.sv
// shared constants and codes for the ring buffer deque
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed widths of the channel fields
  localparam int CMD_W = 3;
  localparam int WORD_W = 32;
  localparam int TOTAL_W = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

### rtl/core/rbd_if.sv
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps
interface rbd_in_if
  import rbd_pkg::*;
();
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic signed [WORD_W-1:0] data_value;

  modport source (output valid, output cmd, output data_value, input ready);
  modport sink (input valid, input cmd, input data_value, output ready);
endinterface

interface rbd_out_if
  import rbd_pkg::*;
();
  logic valid;
  logic ready;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic is_empty;
  logic is_full;
  logic [TOTAL_W-1:0] entry_total;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output front_value, output back_value, output is_empty,
                  output is_full, output entry_total, output status, input ready);
  modport sink (input valid, input front_value, input back_value, input is_empty,
                input is_full, input entry_total, input status, output ready);
endinterface

### rtl/core/rbd_store.sv
// entry store: one write port, two registered read ports
`timescale 1ns / 1ps
module rbd_store
  import rbd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr_a,
  input  logic [IDX_W-1:0]      rd_addr_b,
  output logic [DATA_WIDTH-1:0] rd_data_a_r,
  output logic [DATA_WIDTH-1:0] rd_data_b_r
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // old data on a same-address read; the caller forwards the new word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

endmodule

### rtl/core/ring_buffer_deque_unit.sv
// ring buffer deque: index control, store and result register
// order: an accepted command registers the indices, the store read and the
// forward flags; the result register is loaded from the store read after that
// flow: a new command is accepted only in the idle state, once the store read
// is in the result register; a held result stalls the read stage
// reset: synchronous active-low rst_n empties the queue (indices and count to 0);
// store contents are not cleared, only entries written by a push are ever read
`timescale 1ns / 1ps
module ring_buffer_deque_unit
  import rbd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rbd_in_if.sink    in_ch,
  rbd_out_if.source out_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic accept;
  logic is_empty_now;
  logic is_full_now;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DATA_WIDTH-1:0] word;
  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  logic [DATA_WIDTH-1:0] rd_data_a_r;
  logic [DATA_WIDTH-1:0] rd_data_b_r;

  logic [DATA_WIDTH-1:0] wdata_r;
  logic fwd_a_r;
  logic fwd_b_r;

  logic load_out;
  logic signed [DATA_WIDTH-1:0] front_word;
  logic signed [DATA_WIDTH-1:0] back_word;

  logic out_valid_r;
  logic signed [WORD_W-1:0] front_r;
  logic signed [WORD_W-1:0] back_r;
  logic empty_r;
  logic full_r;
  logic [TOTAL_W-1:0] total_r;
  logic [STATUS_W-1:0] out_status_r;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign is_empty_now = (count_r == '0);
  assign is_full_now = (count_r == CNT_FULL);
  assign word = DATA_WIDTH'(in_ch.data_value);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    count_nxt = count_r;
    status_nxt = STATUS_OK;
    wr_en = 1'b0;
    wr_addr = tail_r;
    case (in_ch.cmd)
      CMD_PUSH_FRONT: begin
        if (is_full_now) begin
          status_nxt = STATUS_OVERFLOW;
        end else begin
          head_nxt = ring_prev(head_r);
          wr_en = accept;
          wr_addr = head_nxt;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full_now) begin
          status_nxt = STATUS_OVERFLOW;
        end else begin
          wr_en = accept;
          wr_addr = tail_r;
          tail_nxt = ring_next(tail_r);
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty_now) begin
          status_nxt = STATUS_UNDERFLOW;
        end else begin
          head_nxt = ring_next(head_r);
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (is_empty_now) begin
          status_nxt = STATUS_UNDERFLOW;
        end else begin
          tail_nxt = ring_prev(tail_r);
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        // peek and unused codes leave the queue alone
      end
    endcase
  end

  assign rd_addr_a = head_nxt;
  assign rd_addr_b = ring_prev(tail_nxt);

  rbd_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (word),
    .rd_en       (accept),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_data_a_r (rd_data_a_r),
    .rd_data_b_r (rd_data_b_r)
  );

  // queue indices and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // forward the pushed word when a read hits the entry being written
  always_ff @(posedge clk) begin
    if (accept) begin
      wdata_r <= word;
      fwd_a_r <= wr_en && (wr_addr == rd_addr_a);
      fwd_b_r <= wr_en && (wr_addr == rd_addr_b);
      status_r <= status_nxt;
    end
  end

  assign load_out = (state_r == S_READ) && (!out_valid_r || out_ch.ready);
  assign front_word = fwd_a_r ? wdata_r : rd_data_a_r;
  assign back_word = fwd_b_r ? wdata_r : rd_data_b_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word register, count_r already holds the updated count here
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (count_r == '0) begin
        front_r <= '0;
        back_r <= '0;
      end else begin
        front_r <= WORD_W'(front_word);
        back_r <= WORD_W'(back_word);
      end
      empty_r <= (count_r == '0);
      full_r <= (count_r == CNT_FULL);
      total_r <= TOTAL_W'(count_r);
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.front_value = front_r;
  assign out_ch.back_value = back_r;
  assign out_ch.is_empty = empty_r;
  assign out_ch.is_full = full_r;
  assign out_ch.entry_total = total_r;
  assign out_ch.status = out_status_r;

endmodule
